[rtl/mme_pkg.sv]
// Shared types, constants and helper functions for the matrix multiply engine.
// Used by mme_cell and matrix_multiply_engine_unit; depends on nothing.
package mme_pkg;

    // Largest matrix dimension the stores and the cell row are built for.
    localparam int MAX_DIM = 8;

    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 36;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Item kinds carried on the input tuser.
    localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

    // Token that walks down the cell row, one per multiply-accumulate step.
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             lastk;
        logic [DIM_W-1:0] k;
    } mme_tok_t;

    // Write request into one cell's column store.
    typedef struct packed {
        logic             en;
        logic [DIM_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } mme_wr_t;

    // A size register of zero means one, anything above MAX_DIM means MAX_DIM.
    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] res;
        if (r == '0)
            res = CNT_W'(1);
        else if (8'(r) > 8'(MAX_DIM))
            res = CNT_W'(MAX_DIM);
        else
            res = CNT_W'(r);
        return res;
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx,
                                      input logic [CNT_W-1:0] n);
        return 8'(idx) < 8'(n);
    endfunction

    function automatic logic is_last(input logic [DIM_W-1:0] idx,
                                     input logic [CNT_W-1:0] n);
        return (CNT_W'(idx) + CNT_W'(1)) == n;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(8'(r) * 8'(MAX_DIM) + 8'(c));
    endfunction

endpackage

[rtl/mme_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mme_cell.sv]
// One cell of the multiply-accumulate row: holds one column of the right operand
// and one accumulator. Depends on mme_pkg and mme_ram.
module mme_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mme_pkg::mme_wr_t             wr,
    input  mme_pkg::mme_tok_t            tok_in,
    input  logic signed [mme_pkg::VAL_W-1:0] a_in,
    output mme_pkg::mme_tok_t            tok_out,
    output logic signed [mme_pkg::VAL_W-1:0] a_out,
    output logic signed [mme_pkg::SUM_W-1:0] acc
);

    logic [mme_pkg::MAX_DIM-1:0]        bvld_reg;
    logic [mme_pkg::VAL_W-1:0]          b_raw;
    logic                               bv_reg;
    mme_pkg::mme_tok_t                  tok1_reg;
    mme_pkg::mme_tok_t                  tok2_reg;
    logic signed [mme_pkg::VAL_W-1:0]   a1_reg;
    logic signed [mme_pkg::VAL_W-1:0]   b_val;
    logic signed [mme_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mme_pkg::SUM_W-1:0]   prod_ext;
    logic signed [mme_pkg::SUM_W-1:0]   acc_reg;
    logic signed [mme_pkg::SUM_W-1:0]   acc_next;

    mme_ram #(
        .WIDTH (mme_pkg::VAL_W),
        .DEPTH (mme_pkg::MAX_DIM)
    ) u_col_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (tok_in.k),
        .rdata (b_raw)
    );

    // Entries never written since reset read as zero.
    assign b_val    = bv_reg ? $signed(b_raw) : '0;
    assign prod_ext = {{(mme_pkg::SUM_W - mme_pkg::PROD_W){prod_reg[mme_pkg::PROD_W-1]}},
                       prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (tok2_reg.vld)
        begin
            acc_next = tok2_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvld_reg <= '0;
            tok1_reg <= '0;
            tok2_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                bvld_reg[wr.addr] <= 1'b1;
            end
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bv_reg   <= bvld_reg[tok_in.k];
        a1_reg   <= a_in;
        prod_reg <= a1_reg * b_val;
        acc_reg  <= acc_next;
    end

    assign tok_out = tok1_reg;
    assign a_out   = a1_reg;
    assign acc     = acc_reg;

endmodule

[rtl/matrix_multiply_engine_unit.sv]
// Top level of the matrix multiply engine: stream ports, configuration, left-operand
// store, sequencer and the row of mme_cell instances. Uses mme_pkg, mme_ram, mme_cell.

// The engine multiplies a left matrix (a_rows x inner_dim) by a right matrix
// (inner_dim x b_cols), elements in signed Q4.12, results exact in signed Q12.24.
// Load transfers (tuser kind 0 = left, 1 = right) write one element each; a load
// whose row or column lies outside the configured sizes is dropped. A compute
// transfer (kind 2) emits every product element in row-major order with tlast on
// the final one; kind 3 is dropped. Both stores read as zero after reset. A compute
// keeps the input closed until its last result has entered the output register:
// for each result row the sequencer streams inner_dim left elements into a row of
// MAX_DIM cells, each cell holding one column of the right operand and one
// accumulator, the token passing one cell per cycle, and then the b_cols
// accumulators drain one per cycle, while the sink is ready, through the output
// register. New input is taken only while no compute is running; a result still
// waiting in the output register does not hold off loads.
module matrix_multiply_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], sum[41:6], zero pad
    output logic        m_axis_tlast,   // last
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam int ND = mme_pkg::MAX_DIM;

    logic [mme_pkg::CFG_W-1:0]  a_rows_reg;
    logic [mme_pkg::CFG_W-1:0]  inner_dim_reg;
    logic [mme_pkg::CFG_W-1:0]  b_cols_reg;
    logic [mme_pkg::CNT_W-1:0]  nr;
    logic [mme_pkg::CNT_W-1:0]  nk;
    logic [mme_pkg::CNT_W-1:0]  nc;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [mme_pkg::DIM_W-1:0]  row_reg;
    logic [mme_pkg::DIM_W-1:0]  row_next;
    logic [mme_pkg::DIM_W-1:0]  k_reg;
    logic [mme_pkg::DIM_W-1:0]  k_next;
    logic [mme_pkg::DIM_W-1:0]  col_reg;
    logic [mme_pkg::DIM_W-1:0]  col_next;

    logic [mme_pkg::IDX_W-1:0]  in_row;
    logic [mme_pkg::IDX_W-1:0]  in_col;
    logic [mme_pkg::VAL_W-1:0]  in_value;
    logic [mme_pkg::KIND_W-1:0] in_kind;
    logic                       s_acc;
    logic                       left_we;
    logic                       right_we;
    logic                       start;

    logic [ND*ND-1:0]           lvld_reg;
    logic                       lv_reg;
    logic [mme_pkg::ADDR_W-1:0] left_raddr;
    logic [mme_pkg::VAL_W-1:0]  left_raw;

    mme_pkg::mme_tok_t          iss_tok;
    mme_pkg::mme_tok_t          tok0_reg;
    mme_pkg::mme_tok_t          tok_chain [ND+1];
    logic signed [mme_pkg::VAL_W-1:0] a_chain [ND+1];
    logic signed [mme_pkg::SUM_W-1:0] acc_arr [ND];
    logic                       fin_reg;

    logic                       emit_fire;
    logic                       out_vld_reg;
    logic [mme_pkg::DIM_W-1:0]  out_row_reg;
    logic [mme_pkg::DIM_W-1:0]  out_col_reg;
    logic [mme_pkg::SUM_W-1:0]  out_sum_reg;
    logic                       out_last_reg;

    // ------------------------------------------------------------------
    // Configuration registers and effective sizes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= mme_pkg::CFG_RESET;
            inner_dim_reg <= mme_pkg::CFG_RESET;
            b_cols_reg    <= mme_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mme_pkg::REG_A_ROWS:    a_rows_reg    <= cfg_data;
                mme_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_data;
                mme_pkg::REG_B_COLS:    b_cols_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign nr = mme_pkg::eff_size(a_rows_reg);
    assign nk = mme_pkg::eff_size(inner_dim_reg);
    assign nc = mme_pkg::eff_size(b_cols_reg);

    // ------------------------------------------------------------------
    // Input decode. Loads and computes are only taken while idle.
    // ------------------------------------------------------------------
    assign in_row   = s_axis_tdata[2:0];
    assign in_col   = s_axis_tdata[5:3];
    assign in_value = s_axis_tdata[21:6];
    assign in_kind  = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign left_we  = s_acc && (in_kind == mme_pkg::KIND_LOAD_LEFT)
                      && mme_pkg::in_range(in_row, nr) && mme_pkg::in_range(in_col, nk);
    assign right_we = s_acc && (in_kind == mme_pkg::KIND_LOAD_RIGHT)
                      && mme_pkg::in_range(in_row, nk) && mme_pkg::in_range(in_col, nc);
    assign start    = s_acc && (in_kind == mme_pkg::KIND_COMPUTE);

    // ------------------------------------------------------------------
    // Left operand store with per-entry valid bits; unwritten entries read zero.
    // ------------------------------------------------------------------
    assign left_raddr = mme_pkg::elem_addr(mme_pkg::IDX_W'(row_reg),
                                           mme_pkg::IDX_W'(k_reg));

    mme_ram #(
        .WIDTH (mme_pkg::VAL_W),
        .DEPTH (ND * ND)
    ) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (mme_pkg::elem_addr(in_row, in_col)),
        .wdata (in_value),
        .raddr (left_raddr),
        .rdata (left_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvld_reg <= '0;
        end
        else if (left_we)
        begin
            lvld_reg[mme_pkg::elem_addr(in_row, in_col)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lv_reg <= lvld_reg[left_raddr];
    end

    // ------------------------------------------------------------------
    // Token issue. The token is registered in tok0_reg to line up with the
    // registered left-store read before it enters the first cell.
    // ------------------------------------------------------------------
    always_comb
    begin
        iss_tok       = '0;
        iss_tok.vld   = (state_reg == ST_ISSUE);
        iss_tok.first = (k_reg == '0);
        iss_tok.lastk = mme_pkg::is_last(k_reg, nk);
        iss_tok.k     = k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            tok0_reg <= iss_tok;
            // The last cell's accumulator takes its final sum once the closing token has passed
            // its tok1_reg and tok2_reg stages; fin_reg moves the sequencer on in time.
            fin_reg  <= tok_chain[ND].vld && tok_chain[ND].lastk;
        end
    end

    assign tok_chain[0] = tok0_reg;
    assign a_chain[0]   = lv_reg ? $signed(left_raw) : '0;

    // ------------------------------------------------------------------
    // Row of cells, one per result column.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < ND; j++)
    begin : g_cell
        mme_pkg::mme_wr_t cell_wr;

        always_comb
        begin
            cell_wr      = '0;
            cell_wr.en   = right_we && (in_col == mme_pkg::IDX_W'(j));
            cell_wr.addr = mme_pkg::DIM_W'(in_row);
            cell_wr.data = in_value;
        end

        mme_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (cell_wr),
            .tok_in  (tok_chain[j]),
            .a_in    (a_chain[j]),
            .tok_out (tok_chain[j+1]),
            .a_out   (a_chain[j+1]),
            .acc     (acc_arr[j])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign emit_fire = (state_reg == ST_EMIT) && (!out_vld_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    row_next   = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (mme_pkg::is_last(k_reg, nk))
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (fin_reg)
                begin
                    col_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    if (!mme_pkg::is_last(col_reg, nc))
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    else if (mme_pkg::is_last(row_reg, nr))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            k_reg     <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            col_reg   <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_sum_reg  <= acc_arr[col_reg];
            out_last_reg <= mme_pkg::is_last(row_reg, nr) && mme_pkg::is_last(col_reg, nc);
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b0, out_sum_reg,
                            mme_pkg::IDX_W'(out_col_reg), mme_pkg::IDX_W'(out_row_reg)};

endmodule
